@@ hw/rtl/dmc_pkg.sv @@
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types, constants and the PLL row table of the display mode check.
// ----------------------------------------------------------------------------
`default_nettype none

package dmc_pkg;

  localparam int unsigned MULTIPLIER_MAX = 63;
  localparam int unsigned RANGE_MAX      = 31;

  localparam int unsigned NUM_ROWS = 3;
  localparam int unsigned ROW_W    = 2;
  localparam int unsigned MAX_STEP = 2000;

  localparam int unsigned MULT_W = $clog2(MULTIPLIER_MAX + 1);
  localparam int unsigned RNG_W  = $clog2(RANGE_MAX + 1);
  localparam int unsigned ACT_W  = $clog2(MAX_STEP * MULTIPLIER_MAX * RANGE_MAX + 1);
  localparam int unsigned ERR_W  = (ACT_W > 22) ? ACT_W : 22;
  localparam int unsigned DIST_W = $clog2(MULTIPLIER_MAX + RANGE_MAX + 64);

  localparam logic [15:0] H_MIN     = 16'd64;
  localparam logic [15:0] H_MAX     = 16'd2048;
  localparam logic [15:0] V_MIN     = 16'd16;
  localparam logic [15:0] V_MAX     = 16'd1536;
  localparam logic [16:0] PORCH_MAX = 17'd256;
  localparam logic [19:0] CLOCK_MAX = 20'd200000;
  localparam logic [34:0] BUF_MAX   = 35'hffffff;
  localparam logic [36:0] MEM_BASE  = 37'hc000;
  localparam logic [36:0] MEM_LIMIT = 37'd33554432;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_HORIZ = 3'd1,
    ST_VERT  = 3'd2,
    ST_SCAN  = 3'd3,
    ST_MEM   = 3'd4,
    ST_CLOCK = 3'd5
  } status_e;

  typedef struct packed {
    logic [15:0] h_active;
    logic [15:0] h_sync_start;
    logic [15:0] h_sync_end;
    logic [15:0] h_total;
    logic [15:0] v_active;
    logic [15:0] v_sync_start;
    logic [15:0] v_sync_end;
    logic [15:0] v_total;
    logic        interlaced;
    logic        double_scan;
    logic [19:0] pixel_clock_khz;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [5:0]  pll_divider;
    logic [4:0]  pll_band;
    logic [5:0]  pll_multiplier;
    logic [4:0]  pll_range;
    logic [21:0] clock_error_khz;
  } out_item_t;

  // classified mode handed from front to back; search runs when status is ok
  typedef struct packed {
    status_e     status;
    logic [19:0] clk_khz;
  } job_t;

  typedef struct packed {
    logic [5:0]  divider;
    logic [4:0]  band;
    logic [4:0]  ref_mult;
    logic [4:0]  ref_range;
    logic [10:0] step;
  } pll_row_t;

  // step is 12000 / divider, exact for every row
  function automatic pll_row_t pll_row(logic [ROW_W-1:0] idx);
    pll_row_t row;
    row = '0;
    case (idx)
      2'd0:    row = '{divider: 6'd12, band: 5'd0,  ref_mult: 5'd13, ref_range: 5'd5,
                       step: 11'd1000};
      2'd1:    row = '{divider: 6'd48, band: 5'd16, ref_mult: 5'd23, ref_range: 5'd17,
                       step: 11'd250};
      2'd2:    row = '{divider: 6'd6,  band: 5'd1,  ref_mult: 5'd11, ref_range: 5'd7,
                       step: 11'd2000};
      default: row = '0;
    endcase
    return row;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dmc_front.sv @@
// ----------------------------------------------------------------------------
// dmc_front
// Takes one mode, checks geometry, scan, memory and clock range, and queues
// the classified job for the PLL search.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  dmc_pkg::in_item_t  data_i,
  output logic               job_push_o,
  input  logic               job_full_i,
  output dmc_pkg::job_t      job_o
);
  import dmc_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_PUSH = 3'b100
  } front_state_e;

  front_state_e state_q, state_d;
  in_item_t     item_q;
  status_e      geo_q, geo_d;
  logic [32:0]  pix_q;
  logic [31:0]  area_q;
  logic [16:0]  va16;
  logic [34:0]  buf3;
  logic [36:0]  mem9;
  logic         mem_bad;
  logic         clk_bad;

  function automatic logic porch_ok(logic [15:0] from, logic [15:0] to);
    logic [16:0] d;
    d = {1'b0, to} - {1'b0, from};
    return !d[16] && (d != 17'd0) && (d <= PORCH_MAX);
  endfunction

  always_comb begin
    if (item_q.h_active < H_MIN || item_q.h_active > H_MAX ||
        item_q.h_active[1:0] != 2'b00 ||
        !porch_ok(item_q.h_sync_start, item_q.h_sync_end) ||
        !porch_ok(item_q.h_sync_end, item_q.h_total)) begin
      geo_d = ST_HORIZ;
    end else if (item_q.v_active < V_MIN || item_q.v_active > V_MAX ||
                 item_q.v_active[1:0] != 2'b00 ||
                 !porch_ok(item_q.v_sync_start, item_q.v_sync_end) ||
                 !porch_ok(item_q.v_sync_end, item_q.v_total)) begin
      geo_d = ST_VERT;
    end else if (item_q.interlaced || item_q.double_scan) begin
      geo_d = ST_SCAN;
    end else begin
      geo_d = ST_OK;
    end
  end

  assign va16 = ({1'b0, item_q.v_active} + 17'd15) & ~17'd15;

  assign buf3    = {2'b00, pix_q} + {1'b0, pix_q, 1'b0};
  assign mem9    = MEM_BASE + {4'b0, pix_q} + {1'b0, pix_q, 3'b000};
  assign mem_bad = (buf3 > BUF_MAX) || (mem9 > MEM_LIMIT) || (|area_q[31:27]);
  assign clk_bad = (item_q.pixel_clock_khz == 20'd0) ||
                   (item_q.pixel_clock_khz > CLOCK_MAX);

  always_comb begin
    job_o.clk_khz = item_q.pixel_clock_khz;
    if (geo_q != ST_OK) begin
      job_o.status = geo_q;
    end else if (mem_bad) begin
      job_o.status = ST_MEM;
    end else if (clk_bad) begin
      job_o.status = ST_CLOCK;
    end else begin
      job_o.status = ST_OK;
    end
  end

  assign full       = (state_q != F_IDLE);
  assign job_push_o = (state_q == F_PUSH) && !job_full_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (push) state_d = F_MUL;
      end
      F_MUL: begin
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!job_full_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && push) begin
      item_q <= data_i;
    end
    if (state_q == F_MUL) begin
      geo_q  <= geo_d;
      pix_q  <= {17'b0, item_q.h_active} * {16'b0, va16};
      area_q <= {16'b0, item_q.h_active} * {16'b0, item_q.v_active};
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/dmc_fifo.sv @@
// ----------------------------------------------------------------------------
// dmc_fifo
// Two-entry job queue between the checking front and the search back.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  dmc_pkg::job_t  data_i,
  input  logic           pop_i,
  output logic           empty_o,
  output dmc_pkg::job_t  data_o
);
  import dmc_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

`default_nettype wire

@@ hw/rtl/dmc_search.sv @@
// ----------------------------------------------------------------------------
// dmc_search
// Walks every row, multiplier and range one candidate per cycle, keeps the
// nearest one and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_search (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_empty_i,
  output logic               job_pop_o,
  input  dmc_pkg::job_t      job_i,
  output logic               empty,
  input  logic               pop,
  output dmc_pkg::out_item_t data_o
);
  import dmc_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_RUN  = 3'b010,
    B_OUT  = 3'b100
  } back_state_e;

  back_state_e       state_q, state_d;
  status_e           st_q;
  logic [19:0]       clk_q;
  logic [ROW_W-1:0]  row_q;
  logic [MULT_W-1:0] m_q;
  logic [RNG_W-1:0]  r_q;
  logic [ERR_W-1:0]  stepm_q, act_q;
  logic              first_q;
  logic [ERR_W-1:0]  best_err_q;
  logic [DIST_W-1:0] best_dist_q;
  logic [5:0]        best_div_q, best_mult_q;
  logic [4:0]        best_band_q, best_rng_q;
  out_item_t         out_q;
  logic              out_valid_q;

  pll_row_t          cur, nxt, first_row;
  logic [ERR_W-1:0]  clk_ext, e;
  logic [DIST_W-1:0] dm, dr, d;
  logic              take, last_r, last_m, last_cand;
  logic [ERR_W+6:0]  err100;
  status_e           fin_status;

  assign cur       = pll_row(row_q);
  assign nxt       = pll_row(row_q + ROW_W'(1));
  assign first_row = pll_row('0);

  assign clk_ext = ERR_W'(clk_q);
  assign e  = (act_q > clk_ext) ? (act_q - clk_ext) : (clk_ext - act_q);
  assign dm = (DIST_W'(m_q) > DIST_W'(cur.ref_mult)) ?
              (DIST_W'(m_q) - DIST_W'(cur.ref_mult)) : (DIST_W'(cur.ref_mult) - DIST_W'(m_q));
  assign dr = (DIST_W'(r_q) > DIST_W'(cur.ref_range)) ?
              (DIST_W'(r_q) - DIST_W'(cur.ref_range)) : (DIST_W'(cur.ref_range) - DIST_W'(r_q));
  assign d  = dm + dr;

  assign take = first_q || (e < best_err_q) || ((e == best_err_q) && (d < best_dist_q));

  assign last_r    = (r_q == RNG_W'(RANGE_MAX));
  assign last_m    = (m_q == MULT_W'(MULTIPLIER_MAX));
  assign last_cand = last_r && last_m && (row_q == ROW_W'(NUM_ROWS - 1));

  // error * 100 against clock is the 1% tolerance
  assign err100 = {1'b0, best_err_q, 6'b0} + {2'b0, best_err_q, 5'b0} +
                  {5'b0, best_err_q, 2'b0};

  always_comb begin
    if (st_q != ST_OK) begin
      fin_status = st_q;
    end else if (err100 > (ERR_W+7)'(clk_q)) begin
      fin_status = ST_CLOCK;
    end else begin
      fin_status = ST_OK;
    end
  end

  assign job_pop_o = (state_q == B_IDLE) && !job_empty_i;
  assign empty     = !out_valid_q;
  assign data_o    = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (!job_empty_i) state_d = (job_i.status == ST_OK) ? B_RUN : B_OUT;
      end
      B_RUN: begin
        if (last_cand) state_d = B_OUT;
      end
      B_OUT: begin
        if (!out_valid_q) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_OUT && !out_valid_q) begin
        out_valid_q <= 1'b1;
      end else if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        if (!job_empty_i) begin
          st_q        <= job_i.status;
          clk_q       <= job_i.clk_khz;
          row_q       <= '0;
          m_q         <= MULT_W'(1);
          r_q         <= RNG_W'(1);
          stepm_q     <= ERR_W'(first_row.step);
          act_q       <= ERR_W'(first_row.step);
          first_q     <= 1'b1;
          best_err_q  <= '0;
          best_dist_q <= '0;
          best_div_q  <= '0;
          best_band_q <= '0;
          best_mult_q <= '0;
          best_rng_q  <= '0;
        end
      end
      B_RUN: begin
        first_q <= 1'b0;
        if (take) begin
          best_err_q  <= e;
          best_dist_q <= d;
          best_div_q  <= cur.divider;
          best_band_q <= cur.band;
          best_mult_q <= 6'(m_q);
          best_rng_q  <= 5'(r_q);
        end
        if (!last_r) begin
          r_q   <= r_q + RNG_W'(1);
          act_q <= act_q + stepm_q;
        end else begin
          r_q <= RNG_W'(1);
          if (!last_m) begin
            m_q     <= m_q + MULT_W'(1);
            stepm_q <= stepm_q + ERR_W'(cur.step);
            act_q   <= stepm_q + ERR_W'(cur.step);
          end else begin
            m_q     <= MULT_W'(1);
            row_q   <= row_q + ROW_W'(1);
            stepm_q <= ERR_W'(nxt.step);
            act_q   <= ERR_W'(nxt.step);
          end
        end
      end
      B_OUT: begin
        if (!out_valid_q) begin
          out_q.status          <= fin_status;
          out_q.pll_divider     <= best_div_q;
          out_q.pll_band        <= best_band_q;
          out_q.pll_multiplier  <= best_mult_q;
          out_q.pll_range       <= best_rng_q;
          out_q.clock_error_khz <= best_err_q[21:0];
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/display_mode_check_pll_search_unit.sv @@
// ----------------------------------------------------------------------------
// display_mode_check_pll_search_unit
// Display mode check with nearest-frequency PLL setting search.
// ----------------------------------------------------------------------------
// Input side is a queue write port: a mode beat is taken when push is high
// and full is low. Result side is a queue read port: the oldest result sits
// on data_o while empty is low and leaves when pop is high.
// One result per mode, in order.
// The front takes each mode through capture, multiply and classify, and it
// hands the job to a two-entry queue; it takes a new mode only once it has
// queued the last one. The back pops a job, walks 3 x 63 x 31 = 5859
// candidates, one per cycle, through a single compare unit, and then loads
// the result into the output register; a mode that fails an early check
// skips the walk and goes from the pop straight to the result load.
// The front keeps taking modes while the back searches, until the queue is
// full. A result waiting in the output register stalls the back only; the
// front and queue keep running.
// Reset empties the queue and the output register; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module display_mode_check_pll_search_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  dmc_pkg::in_item_t  data_i,
  output logic               empty,
  input  logic               pop,
  output dmc_pkg::out_item_t data_o
);
  import dmc_pkg::*;

  logic job_push, job_full, job_pop, job_empty;
  job_t job_in, job_out;

  dmc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .data_i     (data_i),
    .job_push_o (job_push),
    .job_full_i (job_full),
    .job_o      (job_in)
  );

  dmc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .full_o  (job_full),
    .data_i  (job_in),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .data_o  (job_out)
  );

  dmc_search u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .job_i       (job_out),
    .empty       (empty),
    .pop         (pop),
    .data_o      (data_o)
  );

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(job_push && job_full))
    else $error("job queue overrun");

  a_no_pop_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(job_pop && job_empty))
    else $error("job queue underrun");

  a_ok_has_pll : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && data_o.status == ST_OK) |-> (data_o.pll_divider != 6'd0))
    else $error("ok result without PLL setting");

  a_held_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(data_o))
    else $error("waiting result changed");

endmodule

`default_nettype wire
